// ===== rtl/core/polar_ring_sector_binning_assert.svh =====
// Assertion macros for the polar ring and sector binning RTL.
`ifndef POLAR_RING_SECTOR_BINNING_ASSERT_SVH
`define POLAR_RING_SECTOR_BINNING_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked out of reset
`define PRSB_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("prsb assertion failed");

// Next-cycle implication, checked out of reset
`define PRSB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prsb assertion failed");

`else

`define PRSB_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PRSB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/prsb_pkg.sv =====
// Package: payload types, sizes and the sector boundary direction function for polar binning.
package prsb_pkg;

  // Fixed geometry
  localparam int NUM_SECTORS = 16;
  localparam int NUM_RINGS   = 4;
  localparam int EDGE_COUNT  = 5;
  localparam int RING_TESTS  = (NUM_RINGS < EDGE_COUNT - 1) ? NUM_RINGS : EDGE_COUNT - 1;

  // Field and register widths
  localparam int COORD_W = 16;
  localparam int EDGE_W  = 32;
  localparam int SQ_W    = 31;
  localparam int RING_W  = 2;
  localparam int SEC_W   = 4;
  localparam int CELL_W  = 6;
  localparam int IDX_W   = $clog2(EDGE_COUNT);
  localparam int CNT_W   = $clog2(NUM_SECTORS) + 1;
  localparam int BND_W   = 32;

  // Fixed-point angle constants
  localparam logic signed [63:0] Q30_ONE = 64'sd1073741824;
  localparam logic signed [63:0] PI_Q30  = 64'sd3373259426;

  // Reset values of the squared ring edges, 1/4096 square metre
  localparam logic [EDGE_W-1:0] EDGE_RESET [EDGE_COUNT] = '{
    32'd16384, 32'd409600, 32'd1638400, 32'd5017600, 32'd14745600
  };

  // Input transaction: one point
  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
  } point_t;

  // Output transaction: one bin
  typedef struct packed {
    logic              in_range;
    logic [RING_W-1:0] ring_number;
    logic [SEC_W-1:0]  sector_number;
    logic [CELL_W-1:0] cell_number;
  } bin_t;

  // Angular compare results for one point
  typedef struct packed {
    logic [NUM_SECTORS-2:0] ge;
    logic                   origin;
    logic                   neg_axis;
  } ang_t;

  // Boundary direction vector, Q30
  typedef struct packed {
    logic signed [BND_W-1:0] bx;
    logic signed [BND_W-1:0] by;
  } bnd_t;

  typedef struct packed {
    logic signed [63:0] c;
    logic signed [63:0] s;
  } trig_t;

  // Half-plane of a nonzero vector: 0 for [0,pi), 1 for [pi,2pi)
  function automatic logic half_of(input logic signed [BND_W-1:0] vx,
                                   input logic signed [BND_W-1:0] vy);
    return !((vy > 0) || ((vy == 0) && (vx > 0)));
  endfunction

  // Q30 cosine and sine by eight truncated Taylor terms
  function automatic trig_t trig_q30(input logic signed [63:0] a);
    logic signed [63:0] a2;
    logic signed [63:0] ts;
    logic signed [63:0] tc;
    trig_t res;
    a2 = (a * a) >>> 30;
    ts = a;
    tc = Q30_ONE;
    res.s = a;
    res.c = Q30_ONE;
    ts = ((ts * a2) >>> 30) / 6;
    tc = ((tc * a2) >>> 30) / 2;
    res.s = res.s - ts;
    res.c = res.c - tc;
    ts = ((ts * a2) >>> 30) / 20;
    tc = ((tc * a2) >>> 30) / 12;
    res.s = res.s + ts;
    res.c = res.c + tc;
    ts = ((ts * a2) >>> 30) / 42;
    tc = ((tc * a2) >>> 30) / 30;
    res.s = res.s - ts;
    res.c = res.c - tc;
    ts = ((ts * a2) >>> 30) / 72;
    tc = ((tc * a2) >>> 30) / 56;
    res.s = res.s + ts;
    res.c = res.c + tc;
    ts = ((ts * a2) >>> 30) / 110;
    tc = ((tc * a2) >>> 30) / 90;
    res.s = res.s - ts;
    res.c = res.c - tc;
    ts = ((ts * a2) >>> 30) / 156;
    tc = ((tc * a2) >>> 30) / 132;
    res.s = res.s + ts;
    res.c = res.c + tc;
    ts = ((ts * a2) >>> 30) / 210;
    tc = ((tc * a2) >>> 30) / 182;
    res.s = res.s - ts;
    res.c = res.c - tc;
    return res;
  endfunction

  // Direction of boundary k (angle 2*pi*k/NUM_SECTORS), built at elaboration
  function automatic bnd_t boundary_dir(input int k);
    logic signed [63:0] num;
    logic signed [63:0] m;
    logic signed [63:0] r;
    logic signed [63:0] vx;
    logic signed [63:0] vy;
    logic signed [63:0] tmp;
    logic [1:0] turns;
    trig_t cs;
    bnd_t res;
    num = 64'(8 * k);
    m = num / NUM_SECTORS;
    r = num % NUM_SECTORS;
    cs.c = Q30_ONE;
    cs.s = 64'sd0;
    if (r != 0) begin
      cs = trig_q30((r * PI_Q30) / (4 * NUM_SECTORS));
    end
    if (m[0]) begin
      vx = cs.c - cs.s;
      vy = cs.c + cs.s;
    end else begin
      vx = cs.c;
      vy = cs.s;
    end
    turns = m[2:1];
    for (int t = 0; t < 3; t++) begin
      if (t < int'(turns)) begin
        tmp = vx;
        vx = -vy;
        vy = tmp;
      end
    end
    res.bx = vx[BND_W-1:0];
    res.by = vy[BND_W-1:0];
    return res;
  endfunction

endpackage

// ===== rtl/core/prsb_sector.sv =====
// Sector boundary compares: one half-plane test and cross product per boundary.
module prsb_sector (
  input  logic signed [prsb_pkg::COORD_W-1:0] pos_x,
  input  logic signed [prsb_pkg::COORD_W-1:0] pos_y,
  output prsb_pkg::ang_t                      ang
);

  localparam int QW = prsb_pkg::COORD_W + 1;
  localparam int PW = prsb_pkg::BND_W + QW + 1;

  logic signed [QW-1:0] qx;
  logic signed [QW-1:0] qy;
  logic                 hq;

  // Mirror the point through the origin so the angle runs from the negative x axis
  assign qx = -QW'(pos_x);
  assign qy = -QW'(pos_y);
  assign hq = prsb_pkg::half_of(prsb_pkg::BND_W'(qx), prsb_pkg::BND_W'(qy));

  // Flag the origin and the points on the negative x axis, which bypass the boundary compares
  assign ang.origin   = (pos_x == '0) && (pos_y == '0);
  assign ang.neg_axis = (pos_y == '0) && pos_x[prsb_pkg::COORD_W-1];

  // Compare against each interior boundary direction
  for (genvar k = 1; k < prsb_pkg::NUM_SECTORS; k++) begin : g_bnd
    localparam prsb_pkg::bnd_t BND = prsb_pkg::boundary_dir(k);
    localparam logic HB = prsb_pkg::half_of(BND.bx, BND.by);

    logic signed [PW-1:0] prod_a;
    logic signed [PW-1:0] prod_b;
    logic signed [PW-1:0] cross_prod;

    assign prod_a      = PW'(BND.bx) * PW'(qy);
    assign prod_b      = PW'(BND.by) * PW'(qx);
    assign cross_prod  = prod_a - prod_b;
    assign ang.ge[k-1] = (hq != HB) ? (hq && !HB) : !cross_prod[PW-1];
  end

endmodule

// ===== rtl/core/polar_ring_sector_binning.sv =====
// Top level: polar ring and sector binning of one lidar point per transaction.
//
//  channel | direction | payload              | handshake
//  --------+-----------+----------------------+---------------------------
//  pt      | in        | pos_x, pos_y         | pt_valid / pt_stall
//  bin     | out       | range, ring, sector, | bin_valid / bin_stall
//          |           | cell                 |
//  cfg     | in        | five squared edges   | cfg_write, no handshake
//
// One transaction per cycle sustained while bin is not stalled; a transaction
// passes in order through the input register, the product register (squares
// and boundary cross products) and the result register (ring compares and
// sector count), whose valid flag drives bin_valid.
// Reset is synchronous: the pipeline empties and the edges return to defaults.
// A stall on bin holds the result register; earlier stages still advance into
// an empty stage ahead of them. pt_stall rises only when all three stages hold
// a transaction and bin is stalled.
`include "polar_ring_sector_binning_assert.svh"

module polar_ring_sector_binning (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pt_valid,
  output logic                                pt_stall,
  input  prsb_pkg::point_t                    pt,
  output logic                                bin_valid,
  input  logic                                bin_stall,
  output prsb_pkg::bin_t                      bin,
  input  logic                                cfg_write,
  input  logic [prsb_pkg::IDX_W-1:0]          cfg_index,
  input  logic [prsb_pkg::EDGE_W-1:0]         cfg_data
);

  logic [prsb_pkg::EDGE_W-1:0] edges [prsb_pkg::EDGE_COUNT];

  logic             inp_valid;
  prsb_pkg::point_t inp;

  logic                      mid_valid;
  logic [prsb_pkg::SQ_W-1:0] mid_xx;
  logic [prsb_pkg::SQ_W-1:0] mid_yy;
  prsb_pkg::ang_t            mid_ang;

  logic           res_valid;
  prsb_pkg::bin_t res;

  logic in_load;
  logic mid_load;
  logic res_load;

  logic signed [2*prsb_pkg::COORD_W-1:0] sq_x;
  logic signed [2*prsb_pkg::COORD_W-1:0] sq_y;
  prsb_pkg::ang_t                         ang;

  logic [prsb_pkg::EDGE_W-1:0] r2;
  logic                        found;
  logic [prsb_pkg::RING_W-1:0] ring_idx;
  logic [prsb_pkg::CNT_W-1:0]  count;
  logic [prsb_pkg::SEC_W-1:0]  sector;
  prsb_pkg::bin_t              res_next;

  // Stage enables: a stage loads when empty or when its content moves on
  assign res_load = !res_valid || !bin_stall;
  assign mid_load = !mid_valid || res_load;
  assign in_load  = !inp_valid || mid_load;
  assign pt_stall = !in_load;

  assign bin_valid = res_valid;
  assign bin       = res;

  // Write the edge registers; ignore indexes past the list
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < prsb_pkg::EDGE_COUNT; i++) begin
        edges[i] <= prsb_pkg::EDGE_RESET[i];
      end
    end else if (cfg_write && (cfg_index < prsb_pkg::IDX_W'(prsb_pkg::EDGE_COUNT))) begin
      edges[cfg_index] <= cfg_data;
    end
  end

  // Capture the incoming point
  always_ff @(posedge clk) begin
    if (rst) begin
      inp_valid <= 1'b0;
    end else if (in_load) begin
      inp_valid <= pt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      inp <= pt;
    end
  end

  // Form the squares and the boundary compares
  assign sq_x = inp.pos_x * inp.pos_x;
  assign sq_y = inp.pos_y * inp.pos_y;

  prsb_sector u_sector (
    .pos_x (inp.pos_x),
    .pos_y (inp.pos_y),
    .ang   (ang)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (mid_load) begin
      mid_valid <= inp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_load) begin
      mid_xx  <= sq_x[prsb_pkg::SQ_W-1:0];
      mid_yy  <= sq_y[prsb_pkg::SQ_W-1:0];
      mid_ang <= ang;
    end
  end

  // Pick the first ring whose edges bracket the squared radius
  always_comb begin
    r2       = prsb_pkg::EDGE_W'(mid_xx) + prsb_pkg::EDGE_W'(mid_yy);
    found    = 1'b0;
    ring_idx = '0;
    for (int k = prsb_pkg::RING_TESTS - 1; k >= 0; k--) begin
      if ((r2 >= edges[k]) && (r2 < edges[k+1])) begin
        found    = 1'b1;
        ring_idx = prsb_pkg::RING_W'(k);
      end
    end
  end

  // Count the boundaries passed, then apply the origin and negative axis cases
  always_comb begin
    count = '0;
    for (int i = 0; i < prsb_pkg::NUM_SECTORS - 1; i++) begin
      count = count + prsb_pkg::CNT_W'(mid_ang.ge[i]);
    end
    if (count > prsb_pkg::CNT_W'(prsb_pkg::NUM_SECTORS - 1)) begin
      count = prsb_pkg::CNT_W'(prsb_pkg::NUM_SECTORS - 1);
    end
    if (mid_ang.origin) begin
      sector = prsb_pkg::SEC_W'(prsb_pkg::NUM_SECTORS / 2);
    end else if (mid_ang.neg_axis) begin
      sector = prsb_pkg::SEC_W'(prsb_pkg::NUM_SECTORS - 1);
    end else begin
      sector = count[prsb_pkg::SEC_W-1:0];
    end
  end

  // Assemble the result; zero ring and cell when out of range
  always_comb begin
    res_next.in_range      = found;
    res_next.ring_number   = found ? ring_idx : '0;
    res_next.sector_number = sector;
    res_next.cell_number   = found
      ? prsb_pkg::CELL_W'(32'(ring_idx) * 32'(prsb_pkg::NUM_SECTORS) + 32'(sector))
      : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

  // Stall on the input only when every stage is full and the output is held
  `PRSB_ASSERT_IMPL(a_stall_full, clk, rst, pt_stall,
                    inp_valid && mid_valid && res_valid && bin_stall)
  // A held product stage keeps its transaction
  `PRSB_ASSERT_NEXT(a_mid_hold, clk, rst, mid_valid && !res_load, mid_valid)
  // A transaction moving out of the input register lands in the product stage
  `PRSB_ASSERT_NEXT(a_mid_fill, clk, rst, inp_valid && mid_load, mid_valid)
  // An in-range bin carries the cell of its ring and sector
  `PRSB_ASSERT_IMPL(a_cell_match, clk, rst, bin_valid && bin.in_range,
                    bin.cell_number == {bin.ring_number, bin.sector_number})

endmodule
